// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the I2C bit engine.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and codes of the I2C bit engine: command kinds, sequence phases,
// register indexes and the decoded tick item. No dependencies.
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_ACK      = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_e_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_ST_C    = 4'd3,
    PH_P_LOW   = 4'd4,
    PH_P_HIGH  = 4'd5,
    PH_P_END   = 4'd6,
    PH_K_LOW   = 4'd7,
    PH_K_HIGH  = 4'd8,
    PH_A_REL   = 4'd9,
    PH_A_POLL  = 4'd10,
    PH_W_SETUP = 4'd11,
    PH_W_HIGH  = 4'd12,
    PH_W_LOW   = 4'd13,
    PH_R_LOW   = 4'd14,
    PH_R_HIGH  = 4'd15
  } phase_t;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_SETUP       = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [15:0] SETUP_RST       = 16'd1;
  localparam logic [3:0]  POLL_LIMIT_RST  = 4'd9;

  localparam logic [2:0] BIT_LAST = 3'd7;

  // One tick item after decode: cmd_ok is set only for a known command kind.
  typedef struct packed {
    logic       cmd_ok;
    cmd_e_t     cmd;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } tick_t;

endpackage

// ===== rtl/i2cm_front.sv =====
// Front end of the I2C bit engine: takes tick items, decodes the command
// and queues them in a two-entry buffer for the engine. Uses i2cm_pkg.
module i2cm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd_valid,
  input  logic [2:0]           kind,
  input  logic [7:0]           tx_byte,
  input  logic                 ack_bit,
  input  logic                 sda_in,
  output logic                 q_valid,
  output i2cm_pkg::tick_t      q_item,
  input  logic                 q_pop
);
  import i2cm_pkg::*;

  tick_t      slot [2];
  tick_t      dec;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    dec.cmd_ok  = cmd_valid && (kind inside {[CMD_START:CMD_WAIT_ACK]});
    dec.cmd     = cmd_e_t'(kind);
    dec.tx_byte = tx_byte;
    dec.ack_bit = ack_bit;
    dec.sda_in  = sda_in;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/i2cm_engine.sv =====
// Back end of the I2C bit engine: bus sequencer, configuration registers and
// the output register. Uses i2cm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cm_engine #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  input  i2cm_pkg::tick_t      q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_line,
  output logic                 sda_line,
  output logic                 sda_driven,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [7:0]           rx_byte,
  output logic                 nack
);
  import i2cm_pkg::*;

  localparam logic [32:0] CNT_TOP = (33'd1 << COUNTER_WIDTH) - 33'd1;

  logic [15:0] half_period_ticks;
  logic [15:0] setup_ticks;
  logic [3:0]  ack_poll_limit;

  phase_t                   phase, phase_next;
  logic [COUNTER_WIDTH-1:0] time_count, time_count_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [7:0]               data_shift, data_shift_next;
  logic [3:0]               polls_left, polls_left_next;
  logic                     scl_reg, scl_reg_next;
  logic                     sda_reg, sda_reg_next;
  logic                     drive_reg, drive_reg_next;
  logic                     nack_reg, nack_reg_next;
  logic [7:0]               rx_hold, rx_hold_next;
  logic                     done_next;
  logic [COUNTER_WIDTH-1:0] half_ld;
  logic [COUNTER_WIDTH-1:0] setup_ld;

  // Clamp a delay to the counter range, never below one tick.
  function automatic logic [COUNTER_WIDTH-1:0] load_wait(input logic [15:0] n);
    logic [32:0] wide;
    wide = {17'd0, n};
    if (wide > CNT_TOP) begin
      wide = CNT_TOP;
    end
    if (wide == 33'd0) begin
      wide = 33'd1;
    end
    return wide[COUNTER_WIDTH-1:0];
  endfunction

  assign half_ld  = load_wait(half_period_ticks);
  assign setup_ld = load_wait(setup_ticks);

  // Advance one tick whenever an item is queued and the output slot is free or being taken.
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      setup_ticks       <= SETUP_RST;
      ack_poll_limit    <= POLL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        CFG_SETUP:       setup_ticks       <= cfg_data;
        CFG_POLL_LIMIT:  ack_poll_limit    <= cfg_data[3:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    time_count_next = time_count;
    bit_index_next  = bit_index;
    data_shift_next = data_shift;
    polls_left_next = polls_left;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    drive_reg_next  = drive_reg;
    nack_reg_next   = nack_reg;
    rx_hold_next    = rx_hold;
    done_next       = 1'b0;

    if (phase == PH_IDLE) begin
      if (q_item.cmd_ok) begin
        case (q_item.cmd)
          CMD_START: begin
            drive_reg_next  = 1'b1;
            scl_reg_next    = 1'b1;
            sda_reg_next    = 1'b1;
            time_count_next = half_ld;
            phase_next      = PH_ST_A;
          end
          CMD_STOP: begin
            drive_reg_next  = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
            time_count_next = half_ld;
            phase_next      = PH_P_LOW;
          end
          CMD_WRITE: begin
            drive_reg_next  = 1'b1;
            data_shift_next = q_item.tx_byte;
            bit_index_next  = 3'd0;
            sda_reg_next    = q_item.tx_byte[7];
            if (setup_ticks == 16'd0) begin
              scl_reg_next    = 1'b1;
              time_count_next = half_ld;
              phase_next      = PH_W_HIGH;
            end else begin
              scl_reg_next    = 1'b0;
              time_count_next = setup_ld;
              phase_next      = PH_W_SETUP;
            end
          end
          CMD_READ: begin
            drive_reg_next  = 1'b0;
            sda_reg_next    = 1'b1;
            scl_reg_next    = 1'b0;
            bit_index_next  = 3'd0;
            data_shift_next = 8'd0;
            time_count_next = half_ld;
            phase_next      = PH_R_LOW;
          end
          CMD_ACK: begin
            drive_reg_next  = 1'b1;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
            data_shift_next = {7'd0, q_item.ack_bit};
            time_count_next = half_ld;
            phase_next      = PH_K_LOW;
          end
          CMD_WAIT_ACK: begin
            drive_reg_next  = 1'b0;
            sda_reg_next    = 1'b1;
            polls_left_next = ack_poll_limit;
            time_count_next = half_ld;
            phase_next      = PH_A_REL;
          end
          default: ;
        endcase
      end
    end else if (time_count > COUNTER_WIDTH'(1)) begin
      time_count_next = time_count - COUNTER_WIDTH'(1);
    end else begin
      // Wait expired: take the next step of the sequence.
      time_count_next = half_ld;
      case (phase)
        PH_ST_A: begin
          sda_reg_next = 1'b0;
          phase_next   = PH_ST_B;
        end
        PH_ST_B: begin
          scl_reg_next = 1'b0;
          phase_next   = PH_ST_C;
        end
        PH_P_LOW: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_P_HIGH;
        end
        PH_P_HIGH: begin
          sda_reg_next = 1'b1;
          phase_next   = PH_P_END;
        end
        PH_K_LOW: begin
          sda_reg_next = data_shift[0];
          scl_reg_next = 1'b1;
          phase_next   = PH_K_HIGH;
        end
        PH_K_HIGH: begin
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b0;
          phase_next   = PH_IDLE;
        end
        PH_A_REL: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_A_POLL;
        end
        PH_A_POLL: begin
          if (polls_left == 4'd0) begin
            // Timeout: flag and run a stop.
            nack_reg_next  = 1'b1;
            drive_reg_next = 1'b1;
            scl_reg_next   = 1'b0;
            sda_reg_next   = 1'b0;
            phase_next     = PH_P_LOW;
          end else if (!q_item.sda_in) begin
            scl_reg_next   = 1'b0;
            drive_reg_next = 1'b1;
            nack_reg_next  = 1'b0;
            phase_next     = PH_IDLE;
          end else begin
            polls_left_next = polls_left - 4'd1;
          end
        end
        PH_W_SETUP: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_W_HIGH;
        end
        PH_W_HIGH: begin
          scl_reg_next = 1'b0;
          phase_next   = PH_W_LOW;
        end
        PH_W_LOW: begin
          if (bit_index == BIT_LAST) begin
            phase_next = PH_IDLE;
          end else begin
            bit_index_next  = bit_index + 3'd1;
            data_shift_next = {data_shift[6:0], 1'b0};
            sda_reg_next    = data_shift[6];
            if (setup_ticks == 16'd0) begin
              scl_reg_next = 1'b1;
              phase_next   = PH_W_HIGH;
            end else begin
              scl_reg_next    = 1'b0;
              time_count_next = setup_ld;
              phase_next      = PH_W_SETUP;
            end
          end
        end
        PH_R_LOW: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_R_HIGH;
        end
        PH_R_HIGH: begin
          data_shift_next = {data_shift[6:0], q_item.sda_in};
          scl_reg_next    = 1'b0;
          if (bit_index == BIT_LAST) begin
            rx_hold_next = {data_shift[6:0], q_item.sda_in};
            phase_next   = PH_IDLE;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_R_LOW;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (phase_next == PH_IDLE) begin
        time_count_next = '0;
        done_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      time_count <= '0;
      bit_index  <= 3'd0;
      data_shift <= 8'd0;
      polls_left <= 4'd0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      drive_reg  <= 1'b1;
      nack_reg   <= 1'b0;
      rx_hold    <= 8'd0;
    end else if (q_pop) begin
      phase      <= phase_next;
      time_count <= time_count_next;
      bit_index  <= bit_index_next;
      data_shift <= data_shift_next;
      polls_left <= polls_left_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      drive_reg  <= drive_reg_next;
      nack_reg   <= nack_reg_next;
      rx_hold    <= rx_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_line   <= scl_reg_next;
      sda_line   <= sda_reg_next;
      sda_driven <= drive_reg_next;
      busy_res   <= (phase_next != PH_IDLE);
      done_res   <= done_next;
      rx_byte    <= rx_hold_next;
      nack       <= nack_reg_next;
    end
  end

  `ASSERT_IMPLIES(a_busy_has_wait, phase != PH_IDLE, time_count != '0, "busy with no wait loaded")
  `ASSERT_IMPLIES(a_released_high, !drive_reg, sda_reg, "SDA released but level not high")
  `ASSERT_IMPLIES(a_done_is_idle, out_valid && done_res, !busy_res, "done shown while busy")
  `ASSERT_ALWAYS(a_pop_needs_item, !q_pop || q_valid, "tick taken from an empty queue")

endmodule

// ===== rtl/i2c_bit_level_master_unit.sv =====
// I2C bit engine top level: one tick item in, one line-state result out.
// Path: an accepted item waits in the queue, then the sequencer registers its result.
// Throughput: one item per cycle while the result is taken (out_ready); the sequencer advances one tick per item taken.
// Reset (rst, synchronous): idle, SCL and SDA state driven high, nack state clear,
// configuration back to half period 5, setup 1, poll limit 9, queue empty.
module i2c_bit_level_master_unit #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd_valid,
  input  logic [2:0]  kind,
  input  logic [7:0]  tx_byte,
  input  logic        ack_bit,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_line,
  output logic        sda_line,
  output logic        sda_driven,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        nack,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic  q_valid;
  logic  q_pop;
  tick_t q_item;

  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .ack_bit   (ack_bit),
    .sda_in    (sda_in),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  i2cm_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_line   (scl_line),
    .sda_line   (sda_line),
    .sda_driven (sda_driven),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .rx_byte    (rx_byte),
    .nack       (nack)
  );

endmodule
